// ----- hw/rtl/steim2_pkg.sv -----
`default_nettype none

package steim2_pkg;

	// Largest number of samples one blockette may produce.
	localparam int unsigned MAX_BLOCKETTE_SAMPLES = 1024;

	// Number of difference lanes (the widest layout is seven fields).
	localparam int unsigned LANES = 7;

	// Map codes that always select four 8-bit differences.
	localparam logic [1:0] MAP_DIFF0 = 2'd0;
	localparam logic [1:0] MAP_DIFF1 = 2'd1;

	// Map codes that carry a nibble in the top two bits of the word.
	localparam logic [1:0] MAP_DIFF2 = 2'd2;
	localparam logic [1:0] MAP_DIFF3 = 2'd3;

	// Nibble value that has no layout under map code 3.
	localparam logic [1:0] NIB_INVALID = 2'd3;

	// Layout selectors.
	localparam logic [2:0] SUB_4X8  = 3'd0;
	localparam logic [2:0] SUB_1X30 = 3'd1;
	localparam logic [2:0] SUB_2X15 = 3'd2;
	localparam logic [2:0] SUB_3X10 = 3'd3;
	localparam logic [2:0] SUB_5X6  = 3'd4;
	localparam logic [2:0] SUB_6X5  = 3'd5;
	localparam logic [2:0] SUB_7X4  = 3'd6;

	// Field count and field width of each layout, indexed by selector.
	localparam int unsigned LAYOUT_N [LANES] = '{4, 1, 2, 3, 5, 6, 7};
	localparam int unsigned LAYOUT_W [LANES] = '{8, 30, 15, 10, 6, 5, 4};

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCODE = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;

	typedef struct packed {
		logic               first_word;
		logic               last_word;
		logic signed [31:0] start_value;
		logic        [31:0] data_word;
		logic        [1:0]  map_code;
	} word_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic        [9:0]  sample_index;
		logic               last;
		logic        [1:0]  status;
		logic               continuity_break;
	} smp_t;

	// A decoded word as handed from the lane stage to the sample sequencer.
	// Element 0 of diffs is the highest field of the word.
	typedef struct packed {
		logic                   first_word;
		logic                   last_word;
		logic [31:0]            start_value;
		logic                   bad_code;
		logic [2:0]             count;
		logic [LANES-1:0][31:0] diffs;
	} dec_t;

	// Sign-extended field k of a word split into n fields of w bits,
	// counted from the top. Fields past the layout read as zero.
	function automatic logic [31:0] field_of(input logic [31:0] wd, input int unsigned n,
		input int unsigned w, input int unsigned k);
		logic [31:0] mask;
		logic [31:0] v;
		mask = (32'd1 << w) - 32'd1;
		v = '0;
		if (k < n) begin
			v = (wd >> (w * (n - 1 - k))) & mask;
			if (v[w-1]) begin
				v = v | ~mask;
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/steim2_word_decoder_core.sv -----
// A word accepted is registered in the decode stage and loaded into the sequencer, which
// then registers its first sample in the output register. Throughput: one sample per
// cycle while the output is not stalled; the next decoded word follows with no gap.
// The serial add into the running value, one difference per cycle, sets that rate.
// Reset (arst_n low, asynchronous) empties both stages, sets sample_limit to 1024 and
// clears the running value, the sample count and the halt flag.
`default_nettype none

// Steim-2 data word decoder.
//
// A word enters the decode stage, where seven lanes each extract their own
// sign-extended difference for the layout picked by the map code and the
// nibble. The merged lane results, with the field count and the invalid-code
// flag, are registered and then handed to a sequencer that adds the
// differences one per unstalled cycle into the 32-bit running value, highest
// field first. Every sum goes out as one result word with its index in the
// blockette. The sequencer takes the next decoded word in the same cycle that
// it finishes the current one, and the decode stage takes a new word while the
// sequencer is still busy, so the input side only stalls when both are full.
//
// A first word loads the start value and compares it against the running
// value left by the previous blockette; a mismatch against a nonzero value
// marks every result of that word. An invalid code or a sample past the limit
// produces one error result and halts decoding until the next first word.
// After a last word the decoder also halts, keeping the running value for the
// next continuity check.
//
// The sample limit register may only be written while the decoder is idle.
module steim2_word_decoder_core #(
	parameter int unsigned MAX_BLOCKETTE_SAMPLES = steim2_pkg::MAX_BLOCKETTE_SAMPLES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [10:0]       cfg_data,
	input  wire logic              word_valid,
	output logic                   word_ready,
	input  wire steim2_pkg::word_t word_data,
	output logic                   smp_valid,
	input  wire logic              smp_ready,
	output steim2_pkg::smp_t       smp_data
);

	logic [10:0]      sample_limit_q;
	logic             dec_valid;
	logic             dec_take;
	steim2_pkg::dec_t dec_data;

	// The limit register resets to the full blockette size of 1024 samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_limit_q <= 11'd1024;
		end else if (cfg_we) begin
			sample_limit_q <= cfg_data;
		end
	end

	// Lane stage: layout select, seven parallel field extractors and the merge register.
	steim2_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word_data (word_data),
		.dec_valid (dec_valid),
		.dec_take  (dec_take),
		.dec_data  (dec_data)
	);

	// Sequencer: running sum, sample count, halt state and the output register.
	steim2_emit #(
		.MAX_BLOCKETTE_SAMPLES(MAX_BLOCKETTE_SAMPLES)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_limit(sample_limit_q),
		.dec_valid   (dec_valid),
		.dec_take    (dec_take),
		.dec_data    (dec_data),
		.smp_valid   (smp_valid),
		.smp_ready   (smp_ready),
		.smp_data    (smp_data)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/steim2_lane.sv -----
`default_nettype none

// One difference lane: pulls its own field out of the word for every layout.
module steim2_lane #(
	parameter int unsigned LANE = 0
) (
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  sub,
	output logic      [31:0] diff
);

	always_comb begin
		case (sub)
			steim2_pkg::SUB_4X8: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[0],
					steim2_pkg::LAYOUT_W[0], LANE);
			end
			steim2_pkg::SUB_1X30: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[1],
					steim2_pkg::LAYOUT_W[1], LANE);
			end
			steim2_pkg::SUB_2X15: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[2],
					steim2_pkg::LAYOUT_W[2], LANE);
			end
			steim2_pkg::SUB_3X10: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[3],
					steim2_pkg::LAYOUT_W[3], LANE);
			end
			steim2_pkg::SUB_5X6: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[4],
					steim2_pkg::LAYOUT_W[4], LANE);
			end
			steim2_pkg::SUB_6X5: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[5],
					steim2_pkg::LAYOUT_W[5], LANE);
			end
			steim2_pkg::SUB_7X4: begin
				diff = steim2_pkg::field_of(data_word, steim2_pkg::LAYOUT_N[6],
					steim2_pkg::LAYOUT_W[6], LANE);
			end
			default: begin
				diff = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/steim2_decode.sv -----
`default_nettype none

// Selects the layout, runs all lanes on the word and registers the merged result.
module steim2_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                word_valid,
	output logic                     word_ready,
	input  wire steim2_pkg::word_t   word_data,
	output logic                     dec_valid,
	input  wire logic                dec_take,
	output steim2_pkg::dec_t         dec_data
);

	logic [1:0] nib;
	logic [2:0] sub;
	logic       bad;
	logic [steim2_pkg::LANES-1:0][31:0] lane_diff;
	logic       valid_s1;
	steim2_pkg::dec_t data_s1;

	assign nib = word_data.data_word[31:30];

	always_comb begin
		bad = 1'b0;
		case (word_data.map_code)
			steim2_pkg::MAP_DIFF2: begin
				sub = {1'b0, nib};
			end
			steim2_pkg::MAP_DIFF3: begin
				sub = steim2_pkg::SUB_5X6 + {1'b0, nib};
				bad = (nib == steim2_pkg::NIB_INVALID);
			end
			default: begin
				sub = steim2_pkg::SUB_4X8;
			end
		endcase
	end

	for (genvar g = 0; g < steim2_pkg::LANES; g++) begin : g_lane
		steim2_lane #(
			.LANE(g)
		) u_lane (
			.data_word(word_data.data_word),
			.sub      (sub),
			.diff     (lane_diff[g])
		);
	end

	assign word_ready = !valid_s1 || dec_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_ready) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && word_ready) begin
			data_s1.first_word  <= word_data.first_word;
			data_s1.last_word   <= word_data.last_word;
			data_s1.start_value <= word_data.start_value;
			data_s1.bad_code    <= bad;
			data_s1.count       <= bad ? 3'd1 : 3'(steim2_pkg::LAYOUT_N[sub]);
			data_s1.diffs       <= lane_diff;
		end
	end

	assign dec_valid = valid_s1;
	assign dec_data  = data_s1;

endmodule

`default_nettype wire

// ----- hw/rtl/steim2_emit.sv -----
`default_nettype none

// Adds one difference per unstalled cycle to the running value and drives smp_q.
module steim2_emit #(
	parameter int unsigned MAX_BLOCKETTE_SAMPLES = steim2_pkg::MAX_BLOCKETTE_SAMPLES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [10:0]       sample_limit,
	input  wire logic              dec_valid,
	output logic                   dec_take,
	input  wire steim2_pkg::dec_t  dec_data,
	output logic                   smp_valid,
	input  wire logic              smp_ready,
	output steim2_pkg::smp_t       smp_data
);

	localparam int unsigned CNT_W = $clog2(MAX_BLOCKETTE_SAMPLES + 1);
	localparam int unsigned LIM_W = (CNT_W > 11) ? CNT_W : 11;
	localparam int unsigned IDX_W = (CNT_W > 10) ? CNT_W : 10;

	logic [31:0]      running_q;
	logic [CNT_W-1:0] count_q;
	logic             halted_q;
	logic             active_q;
	logic             bad_q;
	logic             lastw_q;
	logic             brk_q;
	logic [2:0]       rem_q;
	logic [steim2_pkg::LANES-1:0][31:0] diffs_q;
	logic             valid_q;
	steim2_pkg::smp_t smp_q;

	logic [LIM_W-1:0] lim_eff;
	logic             over;
	logic             step;
	logic             done;
	logic [31:0]      run_add;
	logic [31:0]      run_post;
	logic [CNT_W-1:0] cnt_post;
	logic             halt_post;
	logic [IDX_W-1:0] idx_ext;
	logic             load;
	logic             brk_new;
	logic             halt_load;
	steim2_pkg::smp_t res;

	always_comb begin
		if (LIM_W'(sample_limit) < LIM_W'(MAX_BLOCKETTE_SAMPLES)) begin
			lim_eff = LIM_W'(sample_limit);
		end else begin
			lim_eff = LIM_W'(MAX_BLOCKETTE_SAMPLES);
		end
	end

	assign over    = LIM_W'(count_q) >= lim_eff;
	assign step    = active_q && (!valid_q || smp_ready);
	assign run_add = running_q + diffs_q[0];
	assign idx_ext = IDX_W'(count_q);

	always_comb begin
		res                  = '0;
		res.status           = steim2_pkg::ST_OK;
		res.continuity_break = brk_q;
		run_post             = running_q;
		cnt_post             = count_q;
		halt_post            = halted_q;
		done                 = 1'b0;
		if (step) begin
			if (bad_q) begin
				res.status = steim2_pkg::ST_BADCODE;
				res.last   = 1'b1;
				done       = 1'b1;
				halt_post  = 1'b1;
			end else if (over) begin
				res.status = steim2_pkg::ST_LIMIT;
				res.last   = 1'b1;
				done       = 1'b1;
				halt_post  = 1'b1;
				run_post   = run_add;
			end else begin
				res.sample       = run_add;
				res.sample_index = idx_ext[9:0];
				res.last         = (rem_q == 3'd1);
				done             = (rem_q == 3'd1);
				run_post         = run_add;
				cnt_post         = count_q + 1'b1;
			end
			if (done && lastw_q) begin
				halt_post = 1'b1;
			end
		end
	end

	// A new word is loaded when the sequencer is free or finishes this cycle.
	assign load      = dec_valid && (!active_q || done);
	assign dec_take  = load;
	assign brk_new   = dec_data.first_word && (run_post != 32'd0)
		&& (dec_data.start_value != run_post);
	assign halt_load = dec_data.first_word ? 1'b0 : halt_post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			count_q   <= '0;
			halted_q  <= 1'b0;
			active_q  <= 1'b0;
		end else if (load) begin
			running_q <= dec_data.first_word ? dec_data.start_value : run_post;
			count_q   <= dec_data.first_word ? '0 : cnt_post;
			halted_q  <= halt_load;
			active_q  <= !halt_load;
		end else if (step) begin
			running_q <= run_post;
			count_q   <= cnt_post;
			halted_q  <= halt_post;
			active_q  <= !done;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bad_q   <= dec_data.bad_code;
			lastw_q <= dec_data.last_word;
			brk_q   <= brk_new;
			rem_q   <= dec_data.count;
			diffs_q <= dec_data.diffs;
		end else if (step) begin
			rem_q   <= rem_q - 3'd1;
			diffs_q <= {32'd0, diffs_q[steim2_pkg::LANES-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (smp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			smp_q <= res;
		end
	end

	assign smp_valid = valid_q;
	assign smp_data  = smp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/steim2_checker.sv -----
`default_nettype none

module steim2_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             smp_valid,
	input wire logic             smp_ready,
	input wire steim2_pkg::smp_t smp_data
);

	// A waiting result word holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_ready |=> smp_valid && $stable(smp_data))
		else $error("result word changed while stalled");

	// An error result ends its word and carries no sample.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && (smp_data.status != steim2_pkg::ST_OK) |->
		smp_data.last && (smp_data.sample == 32'sd0) && (smp_data.sample_index == 10'd0))
		else $error("error result with sample data or without last");

	// Inside a word the next result follows at once, with the next index or a limit error,
	// and keeps the word's continuity flag.
	a_word_run: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && !smp_data.last |=>
		smp_valid && (smp_data.continuity_break == $past(smp_data.continuity_break))
		&& ((smp_data.status == steim2_pkg::ST_LIMIT)
		|| (smp_data.sample_index == $past(smp_data.sample_index) + 10'd1)))
		else $error("results of one word not contiguous");

endmodule

bind steim2_word_decoder_core steim2_checker u_steim2_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.smp_valid(smp_valid),
	.smp_ready(smp_ready),
	.smp_data (smp_data)
);

`default_nettype wire
